// ===== hw/rtl/ows_pkg.sv =====
package ows_pkg;

   // Field widths
   localparam int TASK_ID_W   = 5;
   localparam int COUNT_W     = 4;
   localparam int STATUS_W    = 3;

   // Waiter queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Count after reset and its ceiling
   localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   // Request kinds
   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_ALREADY   = 3'd1,
      ST_BLOCKED   = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_HANDOFF   = 3'd4,
      ST_NOT_OWNER = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   // Core to waiter queue
   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [TASK_ID_W-1:0] push_id;
   } queue_ctrl_type;

   // Waiter queue to core
   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [TASK_ID_W-1:0] head_id;
   } queue_stat_type;

   // One result beat
   typedef struct packed {
      status_type           status;
      logic                 woken_valid;
      logic [TASK_ID_W-1:0] woken_task;
      logic                 owner_valid;
      logic [TASK_ID_W-1:0] owner_task;
      logic [COUNT_W-1:0]   units_left;
   } result_type;

endpackage

// ===== hw/rtl/owned_semaphore_with_wait_queue.sv =====
// Channel   Direction  Handshake              Beat
// req       in         req_valid/req_ready    req_kind, req_task_id
// rsp       out        rsp_valid/rsp_ready    status, woken, owner, units_left
// csr       in         csr_wr_en              csr_wr_data (initial count)
//
// One request per cycle sustained while rsp_ready is high; each result reaches rsp
// from its request beat through the input register, then the result register.
// The decision and the count/owner/queue update happen in the same cycle.
// Reset: count = 1, no owner, waiter queue empty.
// A stalled rsp holds the result register and then the input register;
// req_ready drops only when both are full and rsp_ready is low.
module owned_semaphore_with_wait_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [ows_pkg::TASK_ID_W-1:0] req_task_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ows_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_woken_valid,
   output logic [ows_pkg::TASK_ID_W-1:0] rsp_woken_task,
   output logic                          rsp_owner_valid,
   output logic [ows_pkg::TASK_ID_W-1:0] rsp_owner_task,
   output logic [ows_pkg::COUNT_W-1:0]   rsp_units_left,
   input  logic                          csr_wr_en,
   input  logic [ows_pkg::COUNT_W-1:0]   csr_wr_data
);

   logic                          in_valid_ff;
   logic                          in_kind_ff;
   logic [ows_pkg::TASK_ID_W-1:0] in_task_ff;
   logic                          out_valid_ff;
   ows_pkg::result_type           out_ff;
   ows_pkg::result_type           result_in;
   logic                          advance;
   logic                          req_take;

   // Move a beat from input to result register when the latter frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   ows_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .kind        (in_kind_ff),
      .task_id     (in_task_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result_in)
   );

   // Hold the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_task_ff <= req_task_id;
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = ows_pkg::STATUS_W'(out_ff.status);
   assign rsp_woken_valid = out_ff.woken_valid;
   assign rsp_woken_task  = out_ff.woken_task;
   assign rsp_owner_valid = out_ff.owner_valid;
   assign rsp_owner_task  = out_ff.owner_task;
   assign rsp_units_left  = out_ff.units_left;

   // A handoff wakes exactly the task that becomes owner
   a_handoff_owner : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_ff.status == ows_pkg::ST_HANDOFF) |->
      (rsp_woken_valid && rsp_owner_valid && rsp_owner_task == rsp_woken_task))
      else $error("handoff result does not name the woken task as owner");

   // Only a handoff wakes a waiter
   a_woken_only_handoff : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_woken_valid) |-> (out_ff.status == ows_pkg::ST_HANDOFF))
      else $error("woken task reported without a handoff");

   // A plain release leaves no owner
   a_release_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_ff.status == ows_pkg::ST_RELEASED) |->
      (!rsp_owner_valid && rsp_owner_task == '0))
      else $error("release left an owner in place");

   // A stalled request beat is never dropped
   a_hold_request : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending request lost while stalled");

endmodule

// ===== hw/rtl/ows_queue.sv =====
module ows_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ows_pkg::queue_ctrl_type ctrl,
   output ows_pkg::queue_stat_type stat
);

   logic [ows_pkg::TASK_ID_W-1:0] slot_ff [ows_pkg::QUEUE_DEPTH];
   logic [ows_pkg::QPTR_W-1:0]    head_ff, head_in;
   logic [ows_pkg::QPTR_W-1:0]    tail_ff, tail_in;
   logic [ows_pkg::QFILL_W-1:0]   fill_ff, fill_in;

   // Report head entry and occupancy
   assign stat.empty   = (fill_ff == '0);
   assign stat.full    = (fill_ff == ows_pkg::QFILL_W'(ows_pkg::QUEUE_DEPTH));
   assign stat.head_id = slot_ff[head_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == ows_pkg::QPTR_W'(ows_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : tail_ff + 1'b1;
      end
      if (ctrl.pop) begin
         head_in = (head_ff == ows_pkg::QPTR_W'(ows_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : head_ff + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Store the blocked task at the tail
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         slot_ff[tail_ff] <= ctrl.push_id;
      end
   end

endmodule

// ===== hw/rtl/ows_core.sv =====
module ows_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          kind,
   input  logic [ows_pkg::TASK_ID_W-1:0] task_id,
   input  logic                          csr_wr_en,
   input  logic [ows_pkg::COUNT_W-1:0]   csr_wr_data,
   output ows_pkg::result_type           result
);

   logic [ows_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          holder_valid_ff, holder_valid_in;
   logic [ows_pkg::TASK_ID_W-1:0] holder_id_ff, holder_id_in;
   logic                          is_owner;
   ows_pkg::queue_ctrl_type       qctrl;
   ows_pkg::queue_stat_type       qstat;
   ows_pkg::status_type           status;
   logic                          woken_valid;
   logic                          do_push;
   logic                          do_pop;

   ows_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (qctrl),
      .stat  (qstat)
   );

   assign is_owner = holder_valid_ff && (holder_id_ff == task_id);

   // Decide the outcome of the request in the input register
   always_comb begin
      count_in        = count_ff;
      holder_valid_in = holder_valid_ff;
      holder_id_in    = holder_id_ff;
      woken_valid     = 1'b0;
      do_push         = 1'b0;
      do_pop          = 1'b0;
      status          = ows_pkg::ST_ALREADY;
      if (kind == ows_pkg::KIND_ACQUIRE) begin
         if (is_owner) begin
            status = ows_pkg::ST_ALREADY;
         end else if (count_ff != '0) begin
            count_in        = count_ff - 1'b1;
            holder_valid_in = 1'b1;
            holder_id_in    = task_id;
            status          = ows_pkg::ST_GRANTED;
         end else if (qstat.full) begin
            status = ows_pkg::ST_FULL;
         end else begin
            do_push = 1'b1;
            status  = ows_pkg::ST_BLOCKED;
         end
      end else begin
         if (!is_owner) begin
            status = ows_pkg::ST_NOT_OWNER;
         end else if (qstat.empty) begin
            holder_valid_in = 1'b0;
            holder_id_in    = '0;
            if (count_ff != ows_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            status = ows_pkg::ST_RELEASED;
         end else begin
            // hand the unit straight to the oldest waiter
            do_pop          = 1'b1;
            holder_valid_in = 1'b1;
            holder_id_in    = qstat.head_id;
            woken_valid     = 1'b1;
            status          = ows_pkg::ST_HANDOFF;
         end
      end
   end

   assign qctrl.push    = advance && do_push;
   assign qctrl.pop     = advance && do_pop;
   assign qctrl.push_id = task_id;

   // Build the result beat from the state after this request
   assign result.status      = status;
   assign result.woken_valid = woken_valid;
   assign result.woken_task  = woken_valid ? qstat.head_id : '0;
   assign result.owner_valid = holder_valid_in;
   assign result.owner_task  = holder_valid_in ? holder_id_in : '0;
   assign result.units_left  = count_in;

   // Commit state; a register write reloads the count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= ows_pkg::RESET_COUNT;
         holder_valid_ff <= 1'b0;
         holder_id_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end else if (advance) begin
            count_ff <= count_in;
         end
         if (advance) begin
            holder_valid_ff <= holder_valid_in;
            holder_id_ff    <= holder_id_in;
         end
      end
   end

endmodule
